[hw/rtl/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int HEADER_BYTES = 5;

   localparam logic CSR_START_BYTE   = 1'b0;
   localparam logic CSR_VERSION_BYTE = 1'b1;

   typedef enum logic [1:0] {
      DRAIN_IDLE,
      DRAIN_FETCH,
      DRAIN_SHOW
   } drain_state_type;

   // Handoff from the receiver to the drain at the end of a frame.
   typedef struct packed {
      logic       valid;
      logic       error;
      logic [7:0] frame_type;
      logic [7:0] frame_sequence;
   } job_type;

   // CRC-16, polynomial 0x1021, MSB first, one byte per call.
   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/cfd_if.sv]
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [5:0] frame_length;
   logic [7:0] frame_type;
   logic [7:0] frame_sequence;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic [4:0] payload_index;
   logic       last;

   modport source (output valid, output status, output frame_length,
                   output frame_type, output frame_sequence, output payload_byte,
                   output payload_valid, output payload_index, output last,
                   input ready);
   modport sink (input valid, input status, input frame_length,
                 input frame_type, input frame_sequence, input payload_byte,
                 input payload_valid, input payload_index, input last,
                 output ready);
endinterface

[hw/rtl/cfd_ram.sv]
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cfd_rx.sv]
// ----------------------------------------------------------------------------
// cfd_rx
// Byte parser: hunts for the start byte, checks version and length, runs the
// CRC, writes the payload into the store and hands a job to the drain.
// ----------------------------------------------------------------------------
module cfd_rx #(
   parameter int MAX_PAYLOAD = 32,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
   parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_take,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          start_byte,
   input  logic [7:0]          version_byte,
   output cfd_pkg::job_type    job,
   output logic [LEN_W-1:0]    job_length,
   output logic                store_wr_en,
   output logic [IDX_W-1:0]    store_wr_addr,
   output logic [7:0]          store_wr_data
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 8);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       sequence_ff, sequence_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_high_ff, crc_high_in;
   logic             version_ok_ff, version_ok_in;
   logic [15:0]      crc_next;
   logic [CNT_W-1:0] crc_high_pos;

   assign crc_next     = cfd_pkg::crc_byte_update(crc_ff, rx_byte);
   assign crc_high_pos = CNT_W'(cfd_pkg::HEADER_BYTES) + CNT_W'(length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         length_ff     <= '0;
         type_ff       <= '0;
         sequence_ff   <= '0;
         crc_ff        <= cfd_pkg::CRC_INIT;
         crc_high_ff   <= '0;
         version_ok_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         length_ff     <= length_in;
         type_ff       <= type_in;
         sequence_ff   <= sequence_in;
         crc_ff        <= crc_in;
         crc_high_ff   <= crc_high_in;
         version_ok_ff <= version_ok_in;
      end
   end

   always_comb begin
      count_in      = count_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      sequence_in   = sequence_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      version_ok_in = version_ok_ff;
      job           = '0;
      job_length    = '0;
      store_wr_en   = 1'b0;
      store_wr_addr = IDX_W'(count_ff - CNT_W'(cfd_pkg::HEADER_BYTES));
      store_wr_data = rx_byte;

      if (byte_take) begin
         if (count_ff != '0) begin
            count_in = count_ff + CNT_W'(1);
         end
         priority if (count_ff == CNT_W'(0)) begin
            if (rx_byte == start_byte) begin
               count_in = CNT_W'(1);
            end
         end else if (count_ff == CNT_W'(1)) begin
            version_ok_in = (rx_byte == version_byte);
            crc_in        = crc_next;
         end else if (count_ff == CNT_W'(2)) begin
            if (!version_ok_ff || rx_byte > 8'(MAX_PAYLOAD)) begin
               job.valid = 1'b1;
               job.error = 1'b1;
               count_in  = '0;
            end else begin
               length_in = LEN_W'(rx_byte);
               crc_in    = crc_next;
            end
         end else if (count_ff == CNT_W'(3)) begin
            type_in = rx_byte;
            crc_in  = crc_next;
         end else if (count_ff == CNT_W'(4)) begin
            sequence_in = rx_byte;
            crc_in      = crc_next;
         end else if (count_ff < crc_high_pos) begin
            store_wr_en = 1'b1;
            crc_in      = crc_next;
         end else if (count_ff == crc_high_pos) begin
            crc_high_in = rx_byte;
         end else begin
            job.valid = 1'b1;
            count_in  = '0;
            if ({crc_high_ff, rx_byte} != crc_ff) begin
               job.error = 1'b1;
            end else begin
               job.frame_type     = type_ff;
               job.frame_sequence = sequence_ff;
               job_length         = length_ff;
            end
         end

         // Every end of frame returns the parser to its reset state.
         if (job.valid) begin
            length_in     = '0;
            type_in       = '0;
            sequence_in   = '0;
            crc_in        = cfd_pkg::CRC_INIT;
            crc_high_in   = '0;
            version_ok_in = 1'b0;
         end
      end
   end

endmodule

[hw/rtl/cfd_drain.sv]
// ----------------------------------------------------------------------------
// cfd_drain
// Result sequencer: reads the payload store one entry at a time and presents
// one result per payload byte, or a single result for errors and empty frames.
// ----------------------------------------------------------------------------
module cfd_drain #(
   parameter int MAX_PAYLOAD = 32,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
   parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cfd_pkg::job_type job,
   input  logic [LEN_W-1:0] job_length,
   output logic             busy,
   output logic             store_rd_en,
   output logic [IDX_W-1:0] store_rd_addr,
   input  logic [7:0]       store_rd_data,
   cfd_rsp_if.source        rsp_ch
);

   cfd_pkg::drain_state_type state_ff, state_in;
   logic             error_ff, error_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       sequence_ff, sequence_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             data_run;
   logic             at_last;

   assign data_run = !error_ff && (length_ff != '0);
   assign at_last  = !data_run || ((LEN_W'(idx_ff) + LEN_W'(1)) == length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfd_pkg::DRAIN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      error_ff    <= error_in;
      length_ff   <= length_in;
      type_ff     <= type_in;
      sequence_ff <= sequence_in;
      idx_ff      <= idx_in;
   end

   always_comb begin
      state_in      = state_ff;
      error_in      = error_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      sequence_in   = sequence_ff;
      idx_in        = idx_ff;
      store_rd_en   = 1'b0;
      store_rd_addr = idx_ff;
      rsp_ch.valid  = 1'b0;

      unique case (state_ff)
         cfd_pkg::DRAIN_IDLE: begin
            if (job.valid) begin
               error_in    = job.error;
               length_in   = job_length;
               type_in     = job.frame_type;
               sequence_in = job.frame_sequence;
               idx_in      = '0;
               if (!job.error && job_length != '0) begin
                  state_in = cfd_pkg::DRAIN_FETCH;
               end else begin
                  state_in = cfd_pkg::DRAIN_SHOW;
               end
            end
         end
         cfd_pkg::DRAIN_FETCH: begin
            store_rd_en = 1'b1;
            state_in    = cfd_pkg::DRAIN_SHOW;
         end
         cfd_pkg::DRAIN_SHOW: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               if (at_last) begin
                  state_in = cfd_pkg::DRAIN_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = cfd_pkg::DRAIN_FETCH;
               end
            end
         end
         default: begin
            state_in = cfd_pkg::DRAIN_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != cfd_pkg::DRAIN_IDLE);

   assign rsp_ch.status         = error_ff;
   assign rsp_ch.frame_length   = 6'(length_ff);
   assign rsp_ch.frame_type     = type_ff;
   assign rsp_ch.frame_sequence = sequence_ff;
   assign rsp_ch.payload_byte   = data_run ? store_rd_data : 8'h00;
   assign rsp_ch.payload_valid  = data_run;
   assign rsp_ch.payload_index  = 5'(idx_ff);
   assign rsp_ch.last           = at_last;

endmodule

[hw/rtl/crc_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// crc_frame_deframer_unit
// Byte-serial frame receiver with CRC-16 check and payload replay.
// ----------------------------------------------------------------------------
// While no result run is pending, the block takes one received byte per cycle;
// the CRC-16 is updated for each byte in that same cycle and payload bytes are
// written into a payload RAM. When a frame ends (good CRC, bad CRC, bad version
// or oversized length), input stalls until the last result of that frame has
// been transferred. A good frame with N payload bytes yields N results, each
// read from the RAM through its registered port in the FETCH state and then
// presented in the SHOW state; an error or an empty payload yields a single
// result. No pass over the RAM is needed after reset.
module crc_frame_deframer_unit #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic      clock,
   input  logic      reset,
   cfd_req_if.sink   req_ch,
   cfd_rsp_if.source rsp_ch,
   input  logic      csr_we,
   input  logic      csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0]       start_byte_ff;
   logic [7:0]       version_byte_ff;
   logic             busy;
   logic             byte_take;
   cfd_pkg::job_type job;
   logic [LEN_W-1:0] job_length;
   logic             store_wr_en;
   logic [IDX_W-1:0] store_wr_addr;
   logic [7:0]       store_wr_data;
   logic             store_rd_en;
   logic [IDX_W-1:0] store_rd_addr;
   logic [7:0]       store_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= 8'd170;
         version_byte_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            cfd_pkg::CSR_START_BYTE:   start_byte_ff   <= csr_wdata;
            cfd_pkg::CSR_VERSION_BYTE: version_byte_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = !busy;
   assign byte_take    = req_ch.valid && !busy;

   cfd_rx #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_rx (
      .clock         (clock),
      .reset         (reset),
      .byte_take     (byte_take),
      .rx_byte       (req_ch.rx_byte),
      .start_byte    (start_byte_ff),
      .version_byte  (version_byte_ff),
      .job           (job),
      .job_length    (job_length),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data)
   );

   cfd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   cfd_drain #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_drain (
      .clock         (clock),
      .reset         (reset),
      .job           (job),
      .job_length    (job_length),
      .busy          (busy),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .rsp_ch        (rsp_ch)
   );

endmodule

[bench/tb_deframer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deframer_pkg
// Result layout, CRC-16 step and the frame tracker that predicts and checks
// the results of the frame deframer, one received byte at a time.
// ----------------------------------------------------------------------------
package tb_deframer_pkg;

   import cfd_pkg::*;

   localparam int FRAME_MAX_PAYLOAD = 32;
   localparam int FRAME_HEADER      = 5;

   typedef struct packed {
      logic       status;
      logic [5:0] length;
      logic [7:0] ftype;
      logic [7:0] seq;
      logic [7:0] data;
      logic       data_valid;
      logic [4:0] index;
      logic       last;
   } frame_result_type;

   function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = c[15] ^ data[k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   class frame_tracker;
      logic [7:0]       start_code;
      logic [7:0]       version_code;
      int               position;
      logic [5:0]       length_q;
      logic [7:0]       ftype_q;
      logic [7:0]       seq_q;
      logic [15:0]      crc_q;
      logic [7:0]       crc_high_q;
      bit               version_match;
      logic [7:0]       body_q [FRAME_MAX_PAYLOAD];
      frame_result_type due_results [$];
      int unsigned      results_checked;
      int unsigned      errors_seen;
      int unsigned      failures;

      function new();
         start_code      = 8'hAA;
         version_code    = 8'h01;
         results_checked = 0;
         errors_seen     = 0;
         failures        = 0;
         restart();
      endfunction

      function void set_register(input logic idx, input logic [7:0] value);
         if (idx == CSR_START_BYTE) begin
            start_code = value;
         end else begin
            version_code = value;
         end
      endfunction

      function void restart();
         position      = 0;
         length_q      = '0;
         ftype_q       = '0;
         seq_q         = '0;
         crc_q         = CRC_INIT;
         crc_high_q    = '0;
         version_match = 1'b0;
      endfunction

      function bit mid_frame();
         return position != 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void push_error();
         frame_result_type r;
         r        = '0;
         r.status = 1'b1;
         r.last   = 1'b1;
         due_results.push_back(r);
         errors_seen++;
         restart();
      endfunction

      // Returns 1 when the byte belongs to a frame rather than being dropped.
      function bit take_byte(input logic [7:0] b);
         frame_result_type r;
         int               p;
         p = position;
         if (p == 0) begin
            if (b == start_code) begin
               position = 1;
               return 1'b1;
            end
            return 1'b0;
         end
         position = p + 1;
         if (p == 1) begin
            version_match = (b == version_code);
            crc_q = crc16_next(crc_q, b);
         end else if (p == 2) begin
            if (!version_match || b > FRAME_MAX_PAYLOAD) begin
               push_error();
            end else begin
               length_q = b[5:0];
               crc_q = crc16_next(crc_q, b);
            end
         end else if (p == 3) begin
            ftype_q = b;
            crc_q = crc16_next(crc_q, b);
         end else if (p == 4) begin
            seq_q = b;
            crc_q = crc16_next(crc_q, b);
         end else if (p < FRAME_HEADER + length_q) begin
            body_q[p - FRAME_HEADER] = b;
            crc_q = crc16_next(crc_q, b);
         end else if (p == FRAME_HEADER + length_q) begin
            crc_high_q = b;
         end else if ({crc_high_q, b} != crc_q) begin
            push_error();
         end else begin
            r        = '0;
            r.ftype  = ftype_q;
            r.seq    = seq_q;
            r.last   = 1'b1;
            if (length_q == 0) begin
               due_results.push_back(r);
            end else begin
               r.length     = length_q;
               r.data_valid = 1'b1;
               for (int i = 0; i < length_q; i++) begin
                  r.data  = body_q[i];
                  r.index = i[4:0];
                  r.last  = (i == length_q - 1);
                  due_results.push_back(r);
               end
            end
            restart();
         end
         return 1'b1;
      endfunction

      function string show(input frame_result_type r);
         return $sformatf({"status=%0d len=%0d type=%02h seq=%02h data=%02h",
                           " dv=%0d idx=%0d last=%0d"},
                          r.status, r.length, r.ftype, r.seq, r.data, r.data_valid,
                          r.index, r.last);
      endfunction

      function void match_result(input frame_result_type got);
         frame_result_type want;
         if (due_results.size() == 0) begin
            failures++;
            $display("%0t: result with none expected, expected nothing, actual %s",
                     $time, show(got));
            return;
         end
         want = due_results.pop_front();
         results_checked++;
         if (got !== want) begin
            failures++;
            $display("%0t: result mismatch, expected %s, actual %s",
                     $time, show(want), show(got));
         end
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the frame deframer with random gaps and stalls,
// mixing well-formed frames with corrupted, truncated and noise sequences
// under several start and version settings, and checks every result transfer.
// ----------------------------------------------------------------------------
module tb_top;

   import cfd_pkg::*;
   import tb_deframer_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 12;
   localparam int FULL_FRAME     = 64;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [7:0]       csr_wdata;
   logic [7:0]       cfg_start;
   logic [7:0]       cfg_version;
   logic [7:0]       body [FRAME_MAX_PAYLOAD];
   bit               idle_on = 1'b1;
   int               stall_left = 0;
   int               quiet_cycles = 0;
   int unsigned      frame_bytes = 0;
   frame_tracker     board;
   frame_result_type seen_result;

   cfd_req_if req_ch ();
   cfd_rsp_if rsp_ch ();

   crc_frame_deframer_unit #(
      .MAX_PAYLOAD(FRAME_MAX_PAYLOAD)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (board.take_byte(req_ch.rx_byte)) begin
               frame_bytes++;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_result.status     = rsp_ch.status;
            seen_result.length     = rsp_ch.frame_length;
            seen_result.ftype      = rsp_ch.frame_type;
            seen_result.seq        = rsp_ch.frame_sequence;
            seen_result.data       = rsp_ch.payload_byte;
            seen_result.data_valid = rsp_ch.payload_valid;
            seen_result.index      = rsp_ch.payload_index;
            seen_result.last       = rsp_ch.last;
            board.match_result(seen_result);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic settle_decoder();
      wait_quiet();
      while (board.mid_frame()) begin
         send_byte(8'hFF);
         wait_quiet();
      end
   endtask

   task automatic write_config(input logic [7:0] start_value, input logic [7:0] version_value);
      csr_we <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_wdata <= start_value;
      @(posedge clock);
      csr_index <= CSR_VERSION_BYTE;
      csr_wdata <= version_value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_register(CSR_START_BYTE, start_value);
      board.set_register(CSR_VERSION_BYTE, version_value);
      cfg_start = start_value;
      cfg_version = version_value;
   endtask

   // A header that the block rejects stops after the length byte.
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] len,
                             input logic [7:0] ftype, input logic [7:0] seq,
                             input logic [15:0] crc_flip, input int cut,
                             input bit fill_random);
      logic [7:0]  frame_buf [0:38];
      logic [15:0] crc;
      int          n;
      frame_buf[0] = cfg_start;
      frame_buf[1] = ver;
      frame_buf[2] = len;
      frame_buf[3] = ftype;
      frame_buf[4] = seq;
      n = 3;
      if (ver == cfg_version && len <= FRAME_MAX_PAYLOAD) begin
         crc = CRC_INIT;
         for (int i = 1; i < FRAME_HEADER; i++) begin
            crc = crc16_next(crc, frame_buf[i]);
         end
         for (int i = 0; i < len; i++) begin
            if (fill_random) begin
               body[i] = 8'($urandom_range(0, 255));
            end
            frame_buf[FRAME_HEADER + i] = body[i];
            crc = crc16_next(crc, body[i]);
         end
         crc = crc ^ crc_flip;
         frame_buf[FRAME_HEADER + len] = crc[15:8];
         frame_buf[FRAME_HEADER + len + 1] = crc[7:0];
         n = FRAME_HEADER + len + 2;
      end
      for (int i = 0; i < n && i < cut; i++) begin
         send_byte(frame_buf[i]);
      end
   endtask

   initial begin
      int         pick;
      int         goal;
      int         len;
      logic [7:0] flip;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_START_BYTE;
      csr_wdata = 8'h00;
      reset = 1'b1;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_config(8'hAA, 8'h01);
               send_byte(8'h00);
               send_byte(8'hFF);
               send_frame(8'h01, 8'd0, 8'hFF, 8'h00, 16'h0000, FULL_FRAME, 1'b1);
               send_frame(8'hFE, 8'd1, 8'h00, 8'h00, 16'h0000, FULL_FRAME, 1'b1);
               send_frame(8'h01, 8'd33, 8'h00, 8'h00, 16'h0000, FULL_FRAME, 1'b1);
               send_frame(8'h01, 8'd0, 8'h12, 8'h34, 16'h8000, FULL_FRAME, 1'b1);
               body[0] = 8'hFF;
               body[1] = 8'h00;
               send_frame(8'h01, 8'd2, 8'h00, 8'hFF, 16'h0000, FULL_FRAME, 1'b0);
               wait_quiet();
            end
            1: write_config(8'h00, 8'hFF);
            2: write_config(8'hFF, 8'h00);
            default: begin
               idle_on = 1'b0;
               write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
         endcase

         goal = int'(frame_bytes) + PHASE_BYTES;
         while (frame_bytes < goal) begin
            pick = $urandom_range(0, 9);
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(0, FRAME_MAX_PAYLOAD);
            end
            if ($urandom_range(0, 15) == 0) begin
               len = FRAME_MAX_PAYLOAD;
            end
            case (pick)
               6: send_frame(cfg_version, 8'(len), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)),
                             16'($urandom_range(1, 65535)), FULL_FRAME, 1'b1);
               7: begin
                  if ($urandom_range(0, 1) == 0) begin
                     flip = 8'($urandom_range(1, 255));
                     send_frame(cfg_version ^ flip, 8'(len), 8'h00, 8'h00, 16'h0000,
                                FULL_FRAME, 1'b1);
                  end else begin
                     send_frame(cfg_version,
                                8'($urandom_range(FRAME_MAX_PAYLOAD + 1, 255)),
                                8'h00, 8'h00, 16'h0000, FULL_FRAME, 1'b1);
                  end
               end
               8: begin
                  repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                  settle_decoder();
               end
               9: begin
                  send_frame(cfg_version, 8'(len), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 16'h0000,
                             $urandom_range(1, FRAME_HEADER + len + 1), 1'b1);
                  settle_decoder();
               end
               default: send_frame(cfg_version, 8'(len), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 16'h0000, FULL_FRAME,
                                   1'b1);
            endcase
         end
         settle_decoder();
      end

      $display("Covered %0d frame bytes under four start and version settings.", frame_bytes);
      $display("Checked %0d results, %0d of them frame errors.",
               board.results_checked, board.errors_seen);
      if (board.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
